>>> design/sbusrx_pkg.sv
// ----------------------------------------------------------------------------
// sbusrx_pkg: shared definitions for the SBUS frame receiver
// Frame geometry, register indexes, reset values and the structs that pass
// between the framing, store and unpacking blocks.
// ----------------------------------------------------------------------------
package sbusrx_pkg;

    // Frame geometry.
    localparam int FRAME_BYTES  = 25;
    localparam int CHANNELS     = 16;
    localparam int CHANNEL_BITS = 11;
    localparam int END_POS      = 24;
    localparam int FLAG_POS     = 23;
    localparam int FIRST_DATA   = 1;
    localparam int LOST_BIT     = 5;
    localparam int FAILSAFE_BIT = 4;

    // Derived widths.
    localparam int ADDR_W  = $clog2(FRAME_BYTES);
    localparam int CH_W    = $clog2(CHANNELS);
    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 2;
    // Bit buffer holds at most CHANNEL_BITS-1 leftover bits plus one byte.
    localparam int ACC_W   = CHANNEL_BITS - 1 + BYTE_W;
    localparam int CNT_W   = $clog2(ACC_W + 1);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_START_BYTE = 2'd0;
    localparam logic [IDX_W-1:0] REG_END_BYTE   = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAP_LIMIT  = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0] START_BYTE_RST = 8'd15;
    localparam logic [CFG_W-1:0] END_BYTE_RST   = 8'd0;
    localparam logic [CFG_W-1:0] GAP_LIMIT_RST  = 8'd3;

    // Write request into the frame store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

    // Frame status from the framing logic to the unpacker.
    typedef struct packed {
        logic start;
        logic lost;
        logic failsafe;
    } frame_t;

endpackage

>>> design/sbusrx_if.sv
// ----------------------------------------------------------------------------
// sbusrx_if: valid/ready channels of the SBUS frame receiver
// Byte channel into the block and channel-result channel out of it.
// ----------------------------------------------------------------------------
interface sbusrx_in_if;
    import sbusrx_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output rx_byte, output time_ms, input ready);
    modport sink   (input valid, input rx_byte, input time_ms, output ready);
endinterface

interface sbusrx_out_if;
    import sbusrx_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         channel_index;
    logic [CHANNEL_BITS-1:0] channel_value;
    logic                    lost_frame;
    logic                    failsafe_active;
    logic                    last_of_frame;

    modport source (output valid, output channel_index, output channel_value,
                    output lost_frame, output failsafe_active, output last_of_frame,
                    input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input lost_frame, input failsafe_active, input last_of_frame,
                    output ready);
endinterface

>>> design/sbus_frame_receiver.sv
// ----------------------------------------------------------------------------
// sbus_frame_receiver: SBUS frame receiver
// Collects 25-byte SBUS frames from timestamped serial bytes and emits the
// sixteen 11-bit channels of each good frame together with its flags.
// ----------------------------------------------------------------------------
// Usage:
//   bytes   - one beat per received byte with its millisecond timestamp.
//   results - one beat per channel, channel 0 first; last_of_frame marks
//             channel 15. lost_frame and failsafe_active come from byte 23.
//   cfg_*   - register writes (start byte, end byte, gap limit), done while
//             the block is idle.
// The beat that completes a good frame starts the unpacker, which reads
// the 22 payload bytes one at a time from the frame store, each by a fetch
// and a merge step, through a single shifter, and sends 16 result beats.
// bytes.ready is low while the unpacker runs. A result beat stays on the
// port until taken; a stalled receiver just holds the unpacker in place.
// Reset sets the registers to their defaults, clears the frame position
// and timestamp and leaves the frame store as it is.
// ----------------------------------------------------------------------------
module sbus_frame_receiver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sbusrx_pkg::IDX_W-1:0]    cfg_index,
    input  logic [sbusrx_pkg::CFG_W-1:0]    cfg_data,
    sbusrx_in_if.sink                       bytes,
    sbusrx_out_if.source                    results
);
    import sbusrx_pkg::*;

    store_wr_t         wr;
    frame_t            frame;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              idle;
    logic              accept;

    // Bytes are taken only while the unpacker is idle.
    assign bytes.ready = idle;
    assign accept      = bytes.valid && idle;

    sbusrx_sync u_sync (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (bytes.rx_byte),
        .time_ms   (bytes.time_ms),
        .wr        (wr),
        .frame     (frame)
    );

    sbusrx_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sbusrx_unpack u_unpack (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame),
        .rd_data (rd_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .idle    (idle),
        .res     (results)
    );

endmodule

>>> design/sbusrx_store.sv
// ----------------------------------------------------------------------------
// sbusrx_store: frame byte memory
// One write port from the framing logic, one registered read port for the
// unpacker.
// ----------------------------------------------------------------------------
module sbusrx_store (
    input  logic                                 clk,
    input  sbusrx_pkg::store_wr_t                wr,
    input  logic                                 rd_en,
    input  logic [sbusrx_pkg::ADDR_W-1:0]        rd_addr,
    output logic [sbusrx_pkg::BYTE_W-1:0]        rd_data
);
    import sbusrx_pkg::*;

    logic [BYTE_W-1:0] mem [FRAME_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/sbusrx_sync.sv
// ----------------------------------------------------------------------------
// sbusrx_sync: frame synchronization
// Holds the configuration registers, tracks the frame position, applies the
// inter-byte gap timeout and decides where each byte goes.
// ----------------------------------------------------------------------------
module sbusrx_sync (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sbusrx_pkg::IDX_W-1:0]    cfg_index,
    input  logic [sbusrx_pkg::CFG_W-1:0]    cfg_data,
    input  logic                            accept,
    input  logic [sbusrx_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [sbusrx_pkg::TIME_W-1:0]   time_ms,
    output sbusrx_pkg::store_wr_t           wr,
    output sbusrx_pkg::frame_t              frame
);
    import sbusrx_pkg::*;

    logic [CFG_W-1:0]  start_byte_reg;
    logic [CFG_W-1:0]  end_byte_reg;
    logic [CFG_W-1:0]  gap_limit_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic [TIME_W-1:0] prev_time_reg;
    logic              lost_reg;
    logic              failsafe_reg;

    logic [TIME_W-1:0] delta;
    logic              gap_hit;
    logic [ADDR_W-1:0] pos_eff;
    logic              keep;
    logic              at_end;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            end_byte_reg   <= END_BYTE_RST;
            gap_limit_reg  <= GAP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_BYTE: start_byte_reg <= cfg_data;
                REG_END_BYTE:   end_byte_reg   <= cfg_data;
                REG_GAP_LIMIT:  gap_limit_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Gap timeout: a partial frame restarts when the bytes are too far apart.
    assign delta   = time_ms - prev_time_reg;
    assign gap_hit = (pos_reg != '0) && (delta > TIME_W'(gap_limit_reg));
    assign pos_eff = gap_hit ? '0 : pos_reg;

    // Only the start byte may open a frame.
    assign keep   = accept && !((pos_eff == '0) && (rx_byte != start_byte_reg));
    assign at_end = (pos_eff == ADDR_W'(END_POS));

    assign wr.en   = keep;
    assign wr.addr = pos_eff;
    assign wr.data = rx_byte;

    // Next frame position.
    always_comb
    begin
        priority if (!accept)
        begin
            pos_next = pos_reg;
        end
        else if (!keep || at_end)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_eff + ADDR_W'(1);
        end
    end

    // Position and timestamp.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            prev_time_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            prev_time_reg <= time_ms;
        end
    end

    // Flag byte is captured as it is stored.
    always_ff @(posedge clk)
    begin
        if (keep && (pos_eff == ADDR_W'(FLAG_POS)))
        begin
            lost_reg     <= rx_byte[LOST_BIT];
            failsafe_reg <= rx_byte[FAILSAFE_BIT];
        end
    end

    // A complete frame with the right end byte starts unpacking.
    assign frame.start    = keep && at_end && (rx_byte == end_byte_reg);
    assign frame.lost     = lost_reg;
    assign frame.failsafe = failsafe_reg;

endmodule

>>> design/sbusrx_unpack.sv
// ----------------------------------------------------------------------------
// sbusrx_unpack: channel unpacker
// A small sequencer reads the payload bytes one at a time into a bit buffer
// through one shifter and emits an 11-bit channel whenever enough bits are in.
// ----------------------------------------------------------------------------
module sbusrx_unpack (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sbusrx_pkg::frame_t              frame,
    input  logic [sbusrx_pkg::BYTE_W-1:0]   rd_data,
    output logic                            rd_en,
    output logic [sbusrx_pkg::ADDR_W-1:0]   rd_addr,
    output logic                            idle,
    sbusrx_out_if.source                    res
);
    import sbusrx_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [CNT_W-1:0] CH_BITS = CNT_W'(CHANNEL_BITS);

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              lost_reg, lost_next;
    logic              failsafe_reg, failsafe_next;
    logic [CNT_W-1:0]  cnt_merged;
    logic [CNT_W-1:0]  cnt_left;
    logic              last_ch;

    assign cnt_merged = cnt_reg + CNT_W'(BYTE_W);
    assign cnt_left   = cnt_reg - CH_BITS;
    assign last_ch    = (ch_reg == CH_W'(CHANNELS - 1));

    // Sequencer and bit buffer.
    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        ch_next       = ch_reg;
        lost_next     = lost_reg;
        failsafe_next = failsafe_reg;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame.start)
                begin
                    ptr_next      = ADDR_W'(FIRST_DATA);
                    acc_next      = '0;
                    cnt_next      = '0;
                    ch_next       = '0;
                    lost_next     = frame.lost;
                    failsafe_next = frame.failsafe;
                    state_next    = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                acc_next   = acc_reg | (ACC_W'(rd_data) << cnt_reg);
                cnt_next   = cnt_merged;
                ptr_next   = ptr_reg + ADDR_W'(1);
                state_next = (cnt_merged >= CH_BITS) ? ST_EMIT : ST_FETCH;
            end
            ST_EMIT:
            begin
                if (res.ready)
                begin
                    acc_next = acc_reg >> CHANNEL_BITS;
                    cnt_next = cnt_left;
                    ch_next  = ch_reg + CH_W'(1);
                    priority if (last_ch)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (cnt_left >= CH_BITS)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        ch_reg       <= ch_next;
        lost_reg     <= lost_next;
        failsafe_reg <= failsafe_next;
    end

    // Result beat comes straight from registers.
    assign idle                = (state_reg == ST_IDLE);
    assign res.valid           = (state_reg == ST_EMIT);
    assign res.channel_index   = ch_reg;
    assign res.channel_value   = acc_reg[CHANNEL_BITS-1:0];
    assign res.lost_frame      = lost_reg;
    assign res.failsafe_active = failsafe_reg;
    assign res.last_of_frame   = last_ch;

endmodule

>>> design/sbusrx_checker.sv
// ----------------------------------------------------------------------------
// sbusrx_checker: port-level checks for the SBUS frame receiver
// Watches the byte and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sbusrx_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [sbusrx_pkg::CH_W-1:0]         out_index,
    input  logic [sbusrx_pkg::CHANNEL_BITS-1:0] out_value,
    input  logic                                out_last
);
    import sbusrx_pkg::*;

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index))
        else $error("result beat changed while stalled");

    // No byte is taken while results are being emitted.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("byte channel ready while a result is pending");

    // The last-of-frame mark sits on channel 15 only.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_index == CH_W'(CHANNELS - 1))))
        else $error("last_of_frame does not match channel index");

    // After the last channel the block is ready again; before it, it is not.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> in_ready)
        else $error("block not ready after the last channel");

    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> !in_ready)
        else $error("block ready in the middle of a frame");

endmodule

bind sbus_frame_receiver sbusrx_checker u_sbusrx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (bytes.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_index (results.channel_index),
    .out_value (results.channel_value),
    .out_last  (results.last_of_frame)
);
